FILE: hdl/sl_pkg.sv
// shared types, constants and helper functions of the script lexer
`timescale 1ns / 1ps
package sl_pkg;

  // sizing
  localparam int MAX_TOKEN_LENGTH = 255;
  localparam int POSITION_BITS    = 24;
  localparam int LEN_W            = $clog2(MAX_TOKEN_LENGTH + 1);
  localparam int OUT_POS_W        = 24;
  localparam int FIFO_DEPTH       = 4;
  localparam int FIFO_PTR_W       = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W       = $clog2(FIFO_DEPTH + 1);

  // characters of interest
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;

  // sub-operator codes
  localparam logic [2:0] SUB_NONE = 3'd0;
  localparam logic [2:0] SUB_ADD  = 3'd0;
  localparam logic [2:0] SUB_INC  = 3'd1;
  localparam logic [2:0] SUB_SUB  = 3'd2;
  localparam logic [2:0] SUB_DEC  = 3'd3;
  localparam logic [2:0] SUB_LT   = 3'd0;
  localparam logic [2:0] SUB_LE   = 3'd1;
  localparam logic [2:0] SUB_GT   = 3'd2;
  localparam logic [2:0] SUB_GE   = 3'd3;
  localparam logic [2:0] SUB_EQ   = 3'd4;
  localparam logic [2:0] SUB_NE   = 3'd5;
  localparam logic [2:0] SUB_HASH = 3'd6;

  // what is held between bytes
  typedef enum logic [3:0] {
    PK_NONE  = 4'd0,
    PK_NAME  = 4'd1,
    PK_NUM   = 4'd2,
    PK_PLUS  = 4'd3,
    PK_MINUS = 4'd4,
    PK_LT    = 4'd5,
    PK_GT    = 4'd6,
    PK_EQ    = 4'd7,
    PK_BANG  = 4'd8
  } pend_kind_e;

  typedef enum logic [4:0] {
    CL_NAME      = 5'd0,
    CL_NUMBER    = 5'd1,
    CL_ARITH     = 5'd2,
    CL_COMPARE   = 5'd3,
    CL_READIN    = 5'd4,
    CL_ASSIGN    = 5'd5,
    CL_LOGICAL   = 5'd6,
    CL_NEWLINE   = 5'd7,
    CL_SEMICOLON = 5'd8,
    CL_SLASH     = 5'd9,
    CL_STAR      = 5'd10,
    CL_CARET     = 5'd11,
    CL_PERCENT   = 5'd12,
    CL_LPAREN    = 5'd13,
    CL_RPAREN    = 5'd14,
    CL_LBRACE    = 5'd15,
    CL_RBRACE    = 5'd16,
    CL_QUOTE     = 5'd17,
    CL_COLON     = 5'd18,
    CL_COMMA     = 5'd19,
    CL_DOT       = 5'd20,
    CL_END       = 5'd21,
    CL_ERROR     = 5'd22
  } token_class_e;

  typedef struct packed {
    token_class_e           cls;
    logic [2:0]             sub;
    logic [7:0]             length;
    logic [OUT_POS_W-1:0]   start;
    logic [OUT_POS_W-1:0]   line;
    logic [OUT_POS_W-1:0]   index;
    logic                   last;
  } token_t;

  // up to two tokens produced by one byte
  typedef struct packed {
    logic   a_valid;
    logic   b_valid;
    token_t a;
    token_t b;
  } tok_pair_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b inside {[8'h61:8'h7A]}) || (b inside {[8'h41:8'h5A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  // saturating add of a zero or one to a 24-bit counter
  function automatic logic [OUT_POS_W-1:0] sat_inc(input logic [OUT_POS_W-1:0] v,
                                                   input logic en);
    if (en && (v != {OUT_POS_W{1'b1}})) begin
      return v + 1'b1;
    end
    return v;
  endfunction

  // single-character punctuation, error for anything unknown
  function automatic token_class_e punct_class(input logic [7:0] b);
    case (b)
      CH_SEMI:            return CL_SEMICOLON;
      CH_SLASH:           return CL_SLASH;
      CH_STAR:            return CL_STAR;
      CH_CARET:           return CL_CARET;
      CH_PCT:             return CL_PERCENT;
      CH_LPAR:            return CL_LPAREN;
      CH_RPAR:            return CL_RPAREN;
      CH_LBRC:            return CL_LBRACE;
      CH_RBRC:            return CL_RBRACE;
      CH_DQUOT, CH_SQUOT: return CL_QUOTE;
      CH_COLON:           return CL_COLON;
      CH_COMMA:           return CL_COMMA;
      CH_DOT:             return CL_DOT;
      CH_HASH:            return CL_COMPARE;
      default:            return CL_ERROR;
    endcase
  endfunction

endpackage

FILE: hdl/sl_if.sv
// request channels of the script lexer: text bytes in, tokens out
`timescale 1ns / 1ps
interface sl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface sl_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_class;
  logic [2:0]  sub_operator;
  logic [7:0]  token_length;
  logic [23:0] start_offset;
  logic [23:0] line_number;
  logic [23:0] token_index;
  logic        last_of_item;

  modport source (output valid, output token_class, output sub_operator,
                  output token_length, output start_offset, output line_number,
                  output token_index, output last_of_item, input ready);
  modport sink   (input valid, input token_class, input sub_operator,
                  input token_length, input start_offset, input line_number,
                  input token_index, input last_of_item, output ready);
endinterface

FILE: hdl/sl_lexer_core.sv
// lexer state and per-byte token decision
`timescale 1ns / 1ps
module sl_lexer_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  output sl_pkg::tok_pair_t pair_o
);
  import sl_pkg::*;

  pend_kind_e               pend_q, pend_d;
  logic [LEN_W-1:0]         plen_q, plen_d;
  logic [OUT_POS_W-1:0]     pstart_q, pstart_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [OUT_POS_W-1:0]     line_q, line_d;
  logic [OUT_POS_W-1:0]     tcnt_q, tcnt_d;

  logic [31:0]          pos_ext, plen_ext;
  logic [OUT_POS_W-1:0] here;
  logic [7:0]           plen_out;
  logic                 alpha, digit, alnum;
  logic                 combo, cont;
  token_class_e         c_cls, b_cls;
  logic [2:0]           c_sub;
  logic                 b_counted;
  logic [OUT_POS_W-1:0] idx_a, idx_b;
  logic                 a_valid, b_valid;
  token_t               tok_a, tok_b;

  // offsets and lengths clipped to the output widths
  always_comb begin
    pos_ext  = 32'(pos_q);
    plen_ext = 32'(plen_q);
    here     = (pos_ext > 32'hFF_FFFF) ? {OUT_POS_W{1'b1}} : pos_ext[OUT_POS_W-1:0];
    plen_out = (plen_ext > 32'd255) ? 8'hFF : plen_ext[7:0];
    alpha    = is_alpha(byte_i);
    digit    = is_digit(byte_i);
    alnum    = alpha || digit;
  end

  // two-character operator and name/number continuation
  always_comb begin
    combo = 1'b0;
    c_cls = CL_ARITH;
    c_sub = SUB_NONE;
    if (pend_q == PK_PLUS && byte_i == CH_PLUS) begin
      combo = 1'b1; c_cls = CL_ARITH; c_sub = SUB_INC;
    end else if (pend_q == PK_MINUS && byte_i == CH_MINUS) begin
      combo = 1'b1; c_cls = CL_ARITH; c_sub = SUB_DEC;
    end else if (pend_q == PK_LT && byte_i == CH_EQ) begin
      combo = 1'b1; c_cls = CL_COMPARE; c_sub = SUB_LE;
    end else if (pend_q == PK_LT && byte_i == CH_LT) begin
      combo = 1'b1; c_cls = CL_READIN; c_sub = SUB_NONE;
    end else if (pend_q == PK_GT && byte_i == CH_EQ) begin
      combo = 1'b1; c_cls = CL_COMPARE; c_sub = SUB_GE;
    end else if (pend_q == PK_EQ && byte_i == CH_EQ) begin
      combo = 1'b1; c_cls = CL_COMPARE; c_sub = SUB_EQ;
    end else if (pend_q == PK_BANG && byte_i == CH_EQ) begin
      combo = 1'b1; c_cls = CL_COMPARE; c_sub = SUB_NE;
    end
    cont = (pend_q == PK_NAME && alnum) || (pend_q == PK_NUM && digit);
  end

  // first token: completed operator or flushed pending token
  always_comb begin
    a_valid      = 1'b0;
    tok_a.cls    = CL_NAME;
    tok_a.sub    = SUB_NONE;
    tok_a.length = 8'd1;
    tok_a.start  = pstart_q;
    tok_a.line   = line_q;
    tok_a.index  = '0;
    tok_a.last   = 1'b0;
    if (combo) begin
      a_valid      = 1'b1;
      tok_a.cls    = c_cls;
      tok_a.sub    = c_sub;
      tok_a.length = 8'd2;
    end else if (!cont) begin
      a_valid = (pend_q != PK_NONE);
      case (pend_q)
        PK_NAME:  begin tok_a.cls = CL_NAME;    tok_a.length = plen_out; end
        PK_NUM:   begin tok_a.cls = CL_NUMBER;  tok_a.length = plen_out; end
        PK_PLUS:  begin tok_a.cls = CL_ARITH;   tok_a.sub = SUB_ADD; end
        PK_MINUS: begin tok_a.cls = CL_ARITH;   tok_a.sub = SUB_SUB; end
        PK_LT:    begin tok_a.cls = CL_COMPARE; tok_a.sub = SUB_LT; end
        PK_GT:    begin tok_a.cls = CL_COMPARE; tok_a.sub = SUB_GT; end
        PK_EQ:    tok_a.cls = CL_ASSIGN;
        PK_BANG:  tok_a.cls = CL_LOGICAL;
        default:  tok_a.cls = CL_NAME;
      endcase
    end
  end

  // second token: the byte itself when it stands alone
  always_comb begin
    b_cls        = punct_class(byte_i);
    b_counted    = 1'b0;
    b_valid      = 1'b0;
    tok_b.cls    = b_cls;
    tok_b.sub    = (byte_i == CH_HASH) ? SUB_HASH : SUB_NONE;
    tok_b.length = 8'd1;
    tok_b.start  = here;
    tok_b.line   = line_q;
    tok_b.index  = '0;
    tok_b.last   = 1'b1;
    if (!combo && !cont) begin
      if (byte_i inside {CH_SPACE, CH_TAB, CH_CR} || alnum ||
          byte_i inside {CH_PLUS, CH_MINUS, CH_LT, CH_GT, CH_EQ, CH_BANG}) begin
        b_valid = 1'b0;
      end else if (byte_i == CH_LF) begin
        b_valid   = 1'b1;
        tok_b.cls = CL_NEWLINE;
        tok_b.sub = SUB_NONE;
      end else if (byte_i == CH_NUL) begin
        b_valid      = 1'b1;
        tok_b.cls    = CL_END;
        tok_b.sub    = SUB_NONE;
        tok_b.length = 8'd0;
      end else begin
        b_valid   = 1'b1;
        b_counted = (b_cls != CL_ERROR);
      end
    end
  end

  // running index and last flag on both tokens
  always_comb begin
    idx_a          = sat_inc(tcnt_q, a_valid);
    idx_b          = sat_inc(idx_a, b_valid && b_counted);
    pair_o.a_valid = a_valid;
    pair_o.b_valid = b_valid;
    pair_o.a       = tok_a;
    pair_o.b       = tok_b;
    pair_o.a.index = idx_a;
    pair_o.b.index = idx_b;
    pair_o.a.last  = !b_valid;
    pair_o.b.last  = 1'b1;
  end

  // state update for an accepted byte
  always_comb begin
    pend_d   = pend_q;
    plen_d   = plen_q;
    pstart_d = pstart_q;
    pos_d    = (pos_q != {POSITION_BITS{1'b1}}) ? pos_q + 1'b1 : pos_q;
    line_d   = line_q;
    tcnt_d   = idx_b;
    if (combo) begin
      pend_d = PK_NONE;
      plen_d = '0;
    end else if (cont) begin
      if (plen_ext < 32'(MAX_TOKEN_LENGTH)) begin
        plen_d = plen_q + 1'b1;
      end
    end else begin
      pend_d = PK_NONE;
      plen_d = '0;
      if (alnum || byte_i inside {CH_PLUS, CH_MINUS, CH_LT, CH_GT, CH_EQ, CH_BANG}) begin
        plen_d   = LEN_W'(1);
        pstart_d = here;
        if (alpha)                 pend_d = PK_NAME;
        else if (digit)            pend_d = PK_NUM;
        else if (byte_i == CH_PLUS)  pend_d = PK_PLUS;
        else if (byte_i == CH_MINUS) pend_d = PK_MINUS;
        else if (byte_i == CH_LT)    pend_d = PK_LT;
        else if (byte_i == CH_GT)    pend_d = PK_GT;
        else if (byte_i == CH_EQ)    pend_d = PK_EQ;
        else                         pend_d = PK_BANG;
      end else if (byte_i == CH_LF) begin
        line_d = sat_inc(line_q, 1'b1);
      end else if (byte_i == CH_NUL) begin
        // end of text restarts everything
        pstart_d = '0;
        pos_d    = '0;
        line_d   = OUT_POS_W'(1);
        tcnt_d   = '0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= PK_NONE;
      plen_q   <= '0;
      pstart_q <= '0;
      pos_q    <= '0;
      line_q   <= OUT_POS_W'(1);
      tcnt_q   <= '0;
    end else if (accept_i) begin
      pend_q   <= pend_d;
      plen_q   <= plen_d;
      pstart_q <= pstart_d;
      pos_q    <= pos_d;
      line_q   <= line_d;
      tcnt_q   <= tcnt_d;
    end
  end

endmodule

FILE: hdl/sl_token_fifo.sv
// small token queue that takes up to two tokens and releases one per cycle while popped
`timescale 1ns / 1ps
module sl_token_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sl_pkg::tok_pair_t pair_i,
  input  logic              pop_i,
  output sl_pkg::token_t    head_o,
  output logic              not_empty_o,
  output logic              room_two_o
);
  import sl_pkg::*;

  token_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]            n_push;
  logic                  do_pop;
  token_t                first;

  // push and pop bookkeeping
  always_comb begin
    n_push = push_i ? (2'(pair_i.a_valid) + 2'(pair_i.b_valid)) : 2'd0;
    do_pop = pop_i && (cnt_q != '0);
    first  = pair_i.a_valid ? pair_i.a : pair_i.b;
    wr_d   = wr_q + FIFO_PTR_W'(n_push);
    rd_d   = rd_q + FIFO_PTR_W'(do_pop);
    cnt_d  = cnt_q + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_q] <= first;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_q + 1'b1] <= pair_i.b;
    end
  end

  assign head_o      = mem_q[rd_q];
  assign not_empty_o = (cnt_q != '0);
  assign room_two_o  = (cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));

endmodule

FILE: hdl/script_lexer_unit.sv
// top level of the streaming script lexer
//
//  channel   dir  handshake       payload
//  text_i    in   valid / ready   text_byte
//  token_o   out  valid / ready   class, sub-operator, length, offset, line, index, last
//
// one text byte is taken per cycle while the token queue has room for two tokens;
// a byte's tokens are decided in the cycle it is accepted and are queued at once
// a byte that yields two tokens leaves the queue one token at a time, so the queue drain sets the rate
// reset clears the lexer state and empties the queue; no clearing pass is needed
// a stalled output only holds off input once the four-entry queue is nearly full
`timescale 1ns / 1ps
module script_lexer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  sl_byte_if.sink     text_i,
  sl_token_if.source  token_o
);
  import sl_pkg::*;

  logic      accept;
  logic      pop;
  logic      room_two;
  logic      not_empty;
  tok_pair_t pair;
  token_t    head;

  assign text_i.ready = room_two;
  assign accept       = text_i.valid && room_two;
  assign pop          = token_o.valid && token_o.ready;

  // per-byte decision and lexer state
  sl_lexer_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (text_i.text_byte),
    .pair_o   (pair)
  );

  // output queue
  sl_token_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .pair_i      (pair),
    .pop_i       (pop),
    .head_o      (head),
    .not_empty_o (not_empty),
    .room_two_o  (room_two)
  );

  // result fields
  assign token_o.valid        = not_empty;
  assign token_o.token_class  = head.cls;
  assign token_o.sub_operator = head.sub;
  assign token_o.token_length = head.length;
  assign token_o.start_offset = head.start;
  assign token_o.line_number  = head.line;
  assign token_o.token_index  = head.index;
  assign token_o.last_of_item = head.last;

endmodule

FILE: bench/sl_token_checker.sv
// token checker of the script lexer: predicts the token stream and compares it
`timescale 1ns / 1ps
module sl_token_checker (
  input  logic clk_i,
  input  logic rst_ni,
  sl_byte_if   text_i,
  sl_token_if  token_i,
  output int   fail_count_o,
  output int   outstanding_o
);
  import sl_pkg::*;

  // lexer state as seen by the predictor
  pend_kind_e      held_kind;
  int              held_len;
  logic [23:0]     held_start;
  logic [23:0]     byte_pos;
  logic [23:0]     line_no;
  logic [23:0]     tok_count;

  token_t          byte_tokens[$];
  token_t          expected_tokens[$];
  int              mismatches  = 0;
  int              tokens_seen = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic bit is_letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit is_numeral(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic void lexer_clear();
    held_kind  = PK_NONE;
    held_len   = 0;
    held_start = '0;
    byte_pos   = '0;
    line_no    = 24'd1;
    tok_count  = '0;
  endfunction

  // build one token; counted classes bump the running index first
  function automatic void add_token(input token_class_e c, input logic [2:0] s,
                                    input int len, input logic [23:0] st,
                                    input bit counted);
    token_t t;
    if (counted && tok_count != '1) tok_count++;
    t.cls    = c;
    t.sub    = s;
    t.length = (len > 255) ? 8'hFF : 8'(len);
    t.start  = st;
    t.line   = line_no;
    t.index  = tok_count;
    t.last   = 1'b0;
    byte_tokens.push_back(t);
  endfunction

  // emit whatever is pending as a finished token
  function automatic void close_pending();
    case (held_kind)
      PK_NAME:  add_token(CL_NAME, SUB_NONE, held_len, held_start, 1'b1);
      PK_NUM:   add_token(CL_NUMBER, SUB_NONE, held_len, held_start, 1'b1);
      PK_PLUS:  add_token(CL_ARITH, SUB_ADD, 1, held_start, 1'b1);
      PK_MINUS: add_token(CL_ARITH, SUB_SUB, 1, held_start, 1'b1);
      PK_LT:    add_token(CL_COMPARE, SUB_LT, 1, held_start, 1'b1);
      PK_GT:    add_token(CL_COMPARE, SUB_GT, 1, held_start, 1'b1);
      PK_EQ:    add_token(CL_ASSIGN, SUB_NONE, 1, held_start, 1'b1);
      PK_BANG:  add_token(CL_LOGICAL, SUB_NONE, 1, held_start, 1'b1);
      default: ;
    endcase
    held_kind = PK_NONE;
    held_len  = 0;
  endfunction

  function automatic token_class_e single_class(input logic [7:0] b);
    case (b)
      CH_SEMI:            return CL_SEMICOLON;
      CH_SLASH:           return CL_SLASH;
      CH_STAR:            return CL_STAR;
      CH_CARET:           return CL_CARET;
      CH_PCT:             return CL_PERCENT;
      CH_LPAR:            return CL_LPAREN;
      CH_RPAR:            return CL_RPAREN;
      CH_LBRC:            return CL_LBRACE;
      CH_RBRC:            return CL_RBRACE;
      CH_DQUOT, CH_SQUOT: return CL_QUOTE;
      CH_COLON:           return CL_COLON;
      CH_COMMA:           return CL_COMMA;
      CH_DOT:             return CL_DOT;
      CH_HASH:            return CL_COMPARE;
      default:            return CL_ERROR;
    endcase
  endfunction

  // work out the tokens that one accepted byte causes
  function automatic void predict_byte(input logic [7:0] b);
    logic [23:0]  here;
    bit           taken;
    bit           ended;
    token_class_e c;
    here  = byte_pos;
    taken = 1'b0;
    ended = 1'b0;
    byte_tokens.delete();

    // held operator: try to complete a two-character form
    if (held_kind >= PK_PLUS) begin
      taken = 1'b1;
      if (held_kind == PK_PLUS && b == CH_PLUS)
        add_token(CL_ARITH, SUB_INC, 2, held_start, 1'b1);
      else if (held_kind == PK_MINUS && b == CH_MINUS)
        add_token(CL_ARITH, SUB_DEC, 2, held_start, 1'b1);
      else if (held_kind == PK_LT && b == CH_EQ)
        add_token(CL_COMPARE, SUB_LE, 2, held_start, 1'b1);
      else if (held_kind == PK_LT && b == CH_LT)
        add_token(CL_READIN, SUB_NONE, 2, held_start, 1'b1);
      else if (held_kind == PK_GT && b == CH_EQ)
        add_token(CL_COMPARE, SUB_GE, 2, held_start, 1'b1);
      else if (held_kind == PK_EQ && b == CH_EQ)
        add_token(CL_COMPARE, SUB_EQ, 2, held_start, 1'b1);
      else if (held_kind == PK_BANG && b == CH_EQ)
        add_token(CL_COMPARE, SUB_NE, 2, held_start, 1'b1);
      else
        taken = 1'b0;
      if (taken) begin
        held_kind = PK_NONE;
        held_len  = 0;
      end
    end else if ((held_kind == PK_NAME && (is_letter(b) || is_numeral(b))) ||
                 (held_kind == PK_NUM && is_numeral(b))) begin
      // name or number grows, length saturates
      if (held_len < MAX_TOKEN_LENGTH) held_len++;
      taken = 1'b1;
    end

    // byte not absorbed: close pending token, then handle the byte afresh
    if (!taken) begin
      close_pending();
      if (b == CH_SPACE || b == CH_TAB || b == CH_CR) begin
      end else if (is_letter(b) || is_numeral(b) ||
                   b inside {CH_PLUS, CH_MINUS, CH_LT, CH_GT, CH_EQ, CH_BANG}) begin
        held_kind  = is_letter(b)    ? PK_NAME  :
                     is_numeral(b)   ? PK_NUM   :
                     b == CH_PLUS    ? PK_PLUS  :
                     b == CH_MINUS   ? PK_MINUS :
                     b == CH_LT      ? PK_LT    :
                     b == CH_GT      ? PK_GT    :
                     b == CH_EQ      ? PK_EQ    : PK_BANG;
        held_len   = 1;
        held_start = here;
      end else if (b == CH_LF) begin
        add_token(CL_NEWLINE, SUB_NONE, 1, here, 1'b0);
        if (line_no != '1) line_no++;
      end else if (b == CH_NUL) begin
        add_token(CL_END, SUB_NONE, 0, here, 1'b0);
        lexer_clear();
        ended = 1'b1;
      end else begin
        c = single_class(b);
        if (c == CL_ERROR)
          add_token(CL_ERROR, SUB_NONE, 1, here, 1'b0);
        else
          add_token(c, (b == CH_HASH) ? SUB_HASH : SUB_NONE, 1, here, 1'b1);
      end
    end

    if (!ended && byte_pos != '1) byte_pos++;

    if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size()-1].last = 1'b1;
    foreach (byte_tokens[k]) expected_tokens.push_back(byte_tokens[k]);
  endfunction

  task automatic check_field(input string name, input logic [23:0] got,
                             input logic [23:0] want);
    if (got !== want)
      report_mismatch($sformatf("token %0d %s: got %0d, expected %0d",
                                tokens_seen, name, got, want));
  endtask

  // watch both channels; requests in are predicted before tokens out are checked
  always @(posedge clk_i) begin
    token_t want;
    if (!rst_ni) begin
      lexer_clear();
      expected_tokens.delete();
    end else begin
      if (text_i.valid && text_i.ready) predict_byte(text_i.text_byte);
      if (token_i.valid && token_i.ready) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("token %0d class %0d offset %0d with nothing expected",
                                    tokens_seen, token_i.token_class, token_i.start_offset));
        end else begin
          want = expected_tokens.pop_front();
          check_field("class", 24'(token_i.token_class), 24'(want.cls));
          check_field("sub-operator", 24'(token_i.sub_operator), 24'(want.sub));
          check_field("length", 24'(token_i.token_length), 24'(want.length));
          check_field("start offset", token_i.start_offset, want.start);
          check_field("line", token_i.line_number, want.line);
          check_field("index", token_i.token_index, want.index);
          check_field("last flag", 24'(token_i.last_of_item), 24'(want.last));
        end
        tokens_seen++;
      end
    end
    outstanding_o <= expected_tokens.size();
  end

endmodule

FILE: bench/tb.sv
// top of the script lexer testbench: clock, reset, byte stimulus and verdict
`timescale 1ns / 1ps
module tb;
  import sl_pkg::*;

  localparam int          TEXT_BYTES  = 2000;
  localparam int          BIG_HOLD    = 400;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  logic        clk_i;
  logic        rst_ni;
  int          fail_count;
  int          outstanding;
  int unsigned cycle_count = 0;
  int          sent        = 0;
  bit          send_calm   = 1'b0;
  bit          hold_req    = 1'b0;

  string alnum_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
  string punct_chars = ";/*^%(){}\"':,.#";
  string op_chars    = "+-<>=!#";
  string sep_chars   = " \t\r";
  string op_words[13] = '{"++", "--", "<=", "<<", ">=", "==", "!=",
                          "+", "-", "<", ">", "=", "!"};

  sl_byte_if  text_if ();
  sl_token_if token_if ();

  script_lexer_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (text_if),
    .token_o (token_if)
  );

  sl_token_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .text_i        (text_if),
    .token_i       (token_if),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // 50 MHz clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one byte and wait until it is taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      text_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    text_if.valid     <= 1'b1;
    text_if.text_byte <= b;
    do @(posedge clk_i); while (!text_if.ready);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  task automatic send_name(input int n);
    send_byte(alnum_chars[$urandom_range(0, 51)]);
    repeat (n - 1) send_byte(alnum_chars[$urandom_range(0, 61)]);
  endtask

  task automatic send_number(input int n);
    repeat (n) send_byte(alnum_chars[$urandom_range(52, 61)]);
  endtask

  // well-formed statement with random words, operators and punctuation
  task automatic send_statement();
    int parts;
    parts = $urandom_range(1, 6);
    repeat (parts) begin
      case ($urandom_range(0, 3))
        0:       send_name($urandom_range(1, 8));
        1:       send_number($urandom_range(1, 6));
        2:       send_text(op_words[$urandom_range(0, 12)]);
        default: send_byte(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
      endcase
      if ($urandom_range(0, 1)) send_byte(sep_chars[$urandom_range(0, 2)]);
    end
    case ($urandom_range(0, 2))
      0:       send_byte(CH_SEMI);
      1:       send_byte(CH_LF);
      default: send_text(";\n");
    endcase
  endtask

  // receiver: random stalls, calm stretches, and long hold-offs on request
  initial begin
    int stall_left;
    int calm_left;
    bit calm;
    stall_left = 0;
    calm_left  = 0;
    calm       = 1'b0;
    token_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = BIG_HOLD;
      end
      if (stall_left > 0) begin
        token_if.ready <= 1'b0;
        stall_left--;
      end else begin
        token_if.ready <= 1'b1;
        stall_left = pick_gap(calm);
      end
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(20, 200);
      end else begin
        calm_left--;
      end
    end
  end

  // stimulus and verdict
  initial begin
    int next_hold;
    int r;
    next_hold          = 600;
    rst_ni             = 1'b0;
    text_if.valid      = 1'b0;
    text_if.text_byte  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: letters and digits, all two-character operators but !=, a held operator
    // left incomplete, separators, newline, hash, unknown bytes, end after a name
    send_text("Az9 ++--<=<<>===!>\t;\r\n#");
    send_byte(8'hFF);
    send_byte(8'h80);
    send_text("x");
    send_byte(CH_NUL);

    // random text
    while (sent < TEXT_BYTES) begin
      send_calm = ($urandom_range(0, 7) == 0);
      if (sent >= next_hold) begin
        hold_req  = 1'b1;
        next_hold = next_hold + 900;
      end
      r = $urandom_range(0, 399);
      if (sent >= 300 && sent < 320 || r == 0) begin
        // name at or past the length limit
        send_name($urandom_range(255, 300));
        send_byte(CH_SPACE);
      end else if (sent >= 1200 && sent < 1220 || r == 1) begin
        send_number($urandom_range(255, 300));
        send_byte(CH_LF);
      end else if (r < 280) begin
        send_statement();
      end else if (r < 340) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else if (r < 352) begin
        send_byte(CH_NUL);
      end else if (r < 385) begin
        // operator characters in broken combinations
        repeat ($urandom_range(2, 5)) send_byte(op_chars[$urandom_range(0, 6)]);
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(($urandom_range(0, 1)) ? CH_LF : CH_SPACE);
      end
    end

    text_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
